@@ rtl/ffa_pkg.sv @@
// ffa_pkg: shared constants and the block table entry type of the allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;
    localparam int MAX_BLOCKS  = 64;
    localparam int OFS_W       = 20;
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W      = 32;
    localparam int PSIZE_W     = 21;
    localparam int HDR_W       = 7;
    localparam int FSUM_W      = 21;
    localparam int REQ_W       = 20;
    localparam logic [PSIZE_W-1:0] POOL_LIMIT = PSIZE_W'(1048576);

    // configuration register indexes
    localparam logic [1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [1:0] CFG_POOL_SIZE   = 2'd1;
    localparam logic [1:0] CFG_HEADER_SIZE = 2'd2;

    // operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic [OFS_W-1:0] off;
        logic [OFS_W-1:0] size;
        logic             free;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
endpackage
`default_nettype wire

@@ rtl/ffa_ram.sv @@
// ffa_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/first_fit_block_allocator.sv @@
// first_fit_block_allocator: first-fit allocator over an address-ordered block table
// depends on ffa_pkg and ffa_ram
// operation: the walk reads one table entry a cycle, and a split or merge then moves the
//   entries above it one a cycle through the same ram ports; an empty table is not walked
// throughput: one request at a time; busy drops in the cycle of the result strobe
// reset: synchronous active low; after reset (or a pool size or header write) the block
//   rewrites entry 0 while busy is high; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_func,
    input  wire logic [ffa_pkg::REQ_W-1:0]    i_request_size,
    input  wire logic [ffa_pkg::ADDR_W-1:0]   i_block_address,
    output logic                              o_valid,
    output logic      [ffa_pkg::ADDR_W-1:0]   o_address,
    output logic                              o_ok,
    output logic      [ffa_pkg::FSUM_W-1:0]   o_free_total,
    input  wire logic                         i_cfg_we,
    input  wire logic [1:0]                   i_cfg_idx,
    input  wire logic [ffa_pkg::ADDR_W-1:0]   i_cfg_wdata
);
    import ffa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FNX  = 3'd2;
    localparam logic [2:0] S_SHUP = 3'd3;
    localparam logic [2:0] S_SHDN = 3'd4;
    localparam logic [2:0] S_WNEW = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [ADDR_W-1:0]  r_base;
    logic [PSIZE_W-1:0] r_psize;
    logic [HDR_W-1:0]   r_hdr;
    logic               r_pend, n_pend;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [FSUM_W-1:0]  r_fsum, n_fsum;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_src, n_src;
    logic [IDX_W-1:0]   r_dst, n_dst;
    logic [IDX_W-1:0]   r_last, n_last;
    logic [IDX_W-1:0]   r_ins, n_ins;
    t_entry             r_prev, n_prev;
    t_entry             r_cur, n_cur;
    t_entry             r_new, n_new;
    logic               r_func;
    logic [REQ_W-1:0]   r_req;
    logic [ADDR_W-1:0]  r_rel;
    logic [ADDR_W-1:0]  r_res, n_res;
    logic               r_valid, n_valid;
    logic               r_ok, n_ok;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [FSUM_W-1:0]  r_ft;

    logic               we;
    logic [IDX_W-1:0]   waddr, raddr;
    t_entry             wdata, e;
    logic [ENTRY_W-1:0] rdata;

    logic               accept;
    logic [PSIZE_W-1:0] psat;
    logic [PSIZE_W:0]   hr;
    logic [OFS_W-1:0]   nsize, noff, si1, merged;
    logic               nb_free, pv_free;
    logic [CNT_W:0]     src7;
    logic [CNT_W-1:0]   drop_cnt;

    assign e      = t_entry'(rdata);
    assign busy   = (r_state != S_IDLE) || r_pend;
    assign accept = start && !busy;

    // table ram
    ffa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_tab (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (ENTRY_W'(wdata)),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // datapath helpers
    always_comb begin
        psat     = (r_psize > POOL_LIMIT) ? POOL_LIMIT : r_psize;
        hr       = (PSIZE_W+1)'(r_hdr) + (PSIZE_W+1)'(r_req);
        nsize    = OFS_W'(e.size - OFS_W'(hr) - OFS_W'(1));
        noff     = OFS_W'(e.off + OFS_W'(r_hdr) + nsize + OFS_W'(1));
        nb_free  = ((CNT_W'(r_idx) + CNT_W'(1)) < r_count) && e.free;
        pv_free  = (r_idx != '0) && r_prev.free;
        si1      = nb_free ? OFS_W'(r_cur.size + OFS_W'(r_hdr) + e.size + OFS_W'(1))
                           : r_cur.size;
        merged   = OFS_W'(r_prev.size + OFS_W'(r_hdr) + si1 + OFS_W'(1));
        drop_cnt = CNT_W'(nb_free) + CNT_W'(pv_free);
        src7     = (CNT_W+1)'(r_idx) + (CNT_W+1)'(1) + (CNT_W+1)'(nb_free);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_count = r_count;
        n_fsum  = r_fsum;
        n_idx   = r_idx;
        n_src   = r_src;
        n_dst   = r_dst;
        n_last  = r_last;
        n_ins   = r_ins;
        n_prev  = r_prev;
        n_cur   = r_cur;
        n_new   = r_new;
        n_res   = r_res;
        n_valid = 1'b0;
        n_ok    = 1'b0;
        n_addr  = '0;
        we      = 1'b0;
        waddr   = r_idx;
        wdata   = e;
        raddr   = IDX_W'(r_idx + IDX_W'(1));
        case (r_state)
            S_IDLE: begin
                raddr = '0;
                if (r_pend) begin
                    // rebuild the table as one free block, or empty if the pool is below the header size
                    n_pend = 1'b0;
                    we     = 1'b1;
                    waddr  = '0;
                    wdata  = '{off: '0, size: OFS_W'(psat - PSIZE_W'(r_hdr)), free: 1'b1};
                    if (psat >= PSIZE_W'(r_hdr)) begin
                        n_count = CNT_W'(1);
                        n_fsum  = FSUM_W'(OFS_W'(psat - PSIZE_W'(r_hdr)));
                    end else begin
                        n_count = '0;
                        n_fsum  = '0;
                    end
                end else if (accept) begin
                    n_idx = '0;
                    if (r_count == '0) begin
                        n_valid = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_prev = e;
                if (r_func == FUNC_ALLOC) begin
                    if (e.free && e.size == r_req) begin
                        // exact fit
                        we      = 1'b1;
                        wdata   = '{off: e.off, size: e.size, free: 1'b0};
                        n_fsum  = FSUM_W'(r_fsum - FSUM_W'(e.size));
                        n_valid = 1'b1;
                        n_ok    = 1'b1;
                        n_addr  = ADDR_W'(r_base + ADDR_W'(e.off) + ADDR_W'(r_hdr));
                        n_state = S_IDLE;
                    end else if (e.free && (PSIZE_W+1)'(e.size) > hr) begin
                        if (r_count == CNT_W'(MAX_BLOCKS)) begin
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            // split: shrink this block, carve a used one at its end
                            we      = 1'b1;
                            wdata   = '{off: e.off, size: nsize, free: 1'b1};
                            n_fsum  = FSUM_W'(r_fsum - FSUM_W'(hr) - FSUM_W'(1));
                            n_count = CNT_W'(r_count + CNT_W'(1));
                            n_new   = '{off: noff, size: OFS_W'(r_req), free: 1'b0};
                            n_ins   = IDX_W'(r_idx + IDX_W'(1));
                            n_res   = ADDR_W'(r_base + ADDR_W'(noff) + ADDR_W'(r_hdr));
                            if ((CNT_W'(r_idx) + CNT_W'(1)) < r_count) begin
                                raddr   = IDX_W'(r_count - CNT_W'(1));
                                n_src   = IDX_W'(r_count - CNT_W'(1));
                                n_state = S_SHUP;
                            end else begin
                                n_state = S_WNEW;
                            end
                        end
                    end else if (CNT_W'(r_idx) == CNT_W'(r_count - CNT_W'(1))) begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = IDX_W'(r_idx + IDX_W'(1));
                    end
                end else begin
                    if (ADDR_W'(e.off) + ADDR_W'(r_hdr) == r_rel) begin
                        if (e.free) begin
                            n_valid = 1'b1;
                            n_ok    = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_cur   = e;
                            n_prev  = r_prev;
                            n_state = S_FNX;
                        end
                    end else if (CNT_W'(r_idx) == CNT_W'(r_count - CNT_W'(1))) begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = IDX_W'(r_idx + IDX_W'(1));
                    end
                end
            end
            S_FNX: begin
                // next entry is on the read port, previous one is held
                we = 1'b1;
                if (pv_free) begin
                    waddr = IDX_W'(r_idx - IDX_W'(1));
                    wdata = '{off: r_prev.off, size: merged, free: 1'b1};
                end else begin
                    wdata = '{off: r_cur.off, size: si1, free: 1'b1};
                end
                n_fsum = FSUM_W'(r_fsum + FSUM_W'(r_cur.size)
                                 + (nb_free ? FSUM_W'(r_hdr) + FSUM_W'(1) : '0)
                                 + (pv_free ? FSUM_W'(r_hdr) + FSUM_W'(1) : '0));
                n_count = CNT_W'(r_count - drop_cnt);
                n_last  = IDX_W'(r_count - CNT_W'(1));
                n_src   = IDX_W'(src7);
                n_dst   = IDX_W'(r_idx + IDX_W'(!pv_free));
                raddr   = IDX_W'(src7);
                if (drop_cnt == '0 || src7 >= (CNT_W+1)'(r_count)) begin
                    n_valid = 1'b1;
                    n_ok    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SHDN;
                end
            end
            S_SHDN: begin
                // close the gap left by merged entries
                we    = 1'b1;
                waddr = r_dst;
                wdata = e;
                if (r_src == r_last) begin
                    n_valid = 1'b1;
                    n_ok    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_src = IDX_W'(r_src + IDX_W'(1));
                    n_dst = IDX_W'(r_dst + IDX_W'(1));
                    raddr = IDX_W'(r_src + IDX_W'(1));
                end
            end
            S_SHUP: begin
                // open a slot above the split block, top entry first
                we    = 1'b1;
                waddr = IDX_W'(r_src + IDX_W'(1));
                wdata = e;
                if (r_src == r_ins) begin
                    n_state = S_WNEW;
                end else begin
                    n_src = IDX_W'(r_src - IDX_W'(1));
                    raddr = IDX_W'(r_src - IDX_W'(1));
                end
            end
            S_WNEW: begin
                we      = 1'b1;
                waddr   = r_ins;
                wdata   = r_new;
                n_valid = 1'b1;
                n_ok    = 1'b1;
                n_addr  = r_res;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_we && (i_cfg_idx == CFG_POOL_SIZE || i_cfg_idx == CFG_HEADER_SIZE)) begin
            n_pend = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b1;
            r_count <= '0;
            r_fsum  <= '0;
            r_valid <= 1'b0;
            r_base  <= '0;
            r_psize <= POOL_LIMIT;
            r_hdr   <= HDR_W'(24);
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_fsum  <= n_fsum;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POOL_BASE:   r_base  <= i_cfg_wdata;
                    CFG_POOL_SIZE:   r_psize <= i_cfg_wdata[PSIZE_W-1:0];
                    CFG_HEADER_SIZE: r_hdr   <= i_cfg_wdata[HDR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_last <= n_last;
        r_ins  <= n_ins;
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_new  <= n_new;
        r_res  <= n_res;
        r_ok   <= n_ok;
        r_addr <= n_addr;
        if (n_valid) begin
            r_ft <= n_fsum;
        end
        if (accept) begin
            r_func <= i_func;
            r_req  <= i_request_size;
            r_rel  <= ADDR_W'(i_block_address - r_base);
        end
    end

    assign o_valid      = r_valid;
    assign o_ok         = r_ok;
    assign o_address    = r_addr;
    assign o_free_total = r_ft;

    // checks
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE)) else $error("result strobe outside idle");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS)) else $error("block count above table depth");
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_valid)) else $error("accepted request dropped");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_address == '0)) else $error("failed result with address");
endmodule
`default_nettype wire

@@ sim/ffa_checker.sv @@
// ffa_checker: watches the request, result and register ports of the allocator,
// predicts every result from its own copy of the block table and compares
// depends on ffa_pkg
`timescale 1ns / 1ps
module ffa_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic                        i_func,
    input  logic [ffa_pkg::REQ_W-1:0]   i_request_size,
    input  logic [ffa_pkg::ADDR_W-1:0]  i_block_address,
    input  logic                        i_valid,
    input  logic [ffa_pkg::ADDR_W-1:0]  i_address,
    input  logic                        i_ok,
    input  logic [ffa_pkg::FSUM_W-1:0]  i_free_total,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [ffa_pkg::ADDR_W-1:0]  i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import ffa_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic              ok;
        logic [FSUM_W-1:0] free_total;
    } t_alloc_result;

    t_alloc_result     result_q[$];

    // shadow registers and block table
    logic [ADDR_W-1:0]  base_r;
    logic [PSIZE_W-1:0] psize_r;
    logic [HDR_W-1:0]   hdr_r;
    logic [OFS_W-1:0]   tab_off  [MAX_BLOCKS];
    logic [OFS_W-1:0]   tab_size [MAX_BLOCKS];
    logic               tab_free [MAX_BLOCKS];
    int                 blk_cnt;

    function automatic void rebuild_table();
        longint unsigned p;
        p = psize_r;
        if (p > POOL_LIMIT) p = POOL_LIMIT;
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            tab_off[k]  = '0;
            tab_size[k] = '0;
            tab_free[k] = 1'b0;
        end
        blk_cnt = 0;
        if (p >= hdr_r) begin
            tab_size[0] = OFS_W'(p - hdr_r);
            tab_free[0] = 1'b1;
            blk_cnt     = 1;
        end
    endfunction

    function automatic logic [FSUM_W-1:0] free_bytes();
        longint unsigned s;
        s = 0;
        for (int k = 0; k < blk_cnt; k++)
            if (tab_free[k]) s += tab_size[k];
        return FSUM_W'(s);
    endfunction

    function automatic void drop_entry(int k);
        for (int j = k; j + 1 < blk_cnt; j++) begin
            tab_off[j]  = tab_off[j+1];
            tab_size[j] = tab_size[j+1];
            tab_free[j] = tab_free[j+1];
        end
        if (blk_cnt > 0) blk_cnt--;
    endfunction

    // first fit with split from the end of the block
    function automatic t_alloc_result predict_alloc(logic [REQ_W-1:0] req);
        t_alloc_result    r;
        longint unsigned  need;
        longint unsigned  nsize;
        logic [OFS_W-1:0] noff;
        r    = '{address: '0, ok: 1'b0, free_total: '0};
        need = longint'(hdr_r) + req;
        for (int i = 0; i < blk_cnt; i++) begin
            if (!tab_free[i]) continue;
            if (tab_size[i] == req) begin
                tab_free[i] = 1'b0;
                r.address = base_r + ADDR_W'(tab_off[i]) + ADDR_W'(hdr_r);
                r.ok = 1'b1;
                break;
            end
            if (tab_size[i] > need) begin
                if (blk_cnt >= MAX_BLOCKS) break;
                nsize = tab_size[i] - (need + 1);
                noff  = OFS_W'(tab_off[i] + hdr_r + nsize + 1);
                tab_size[i] = OFS_W'(nsize);
                for (int j = blk_cnt; j > i + 1; j--) begin
                    tab_off[j]  = tab_off[j-1];
                    tab_size[j] = tab_size[j-1];
                    tab_free[j] = tab_free[j-1];
                end
                tab_off[i+1]  = noff;
                tab_size[i+1] = OFS_W'(req);
                tab_free[i+1] = 1'b0;
                blk_cnt++;
                r.address = base_r + ADDR_W'(noff) + ADDR_W'(hdr_r);
                r.ok = 1'b1;
                break;
            end
        end
        r.free_total = free_bytes();
        return r;
    endfunction

    // release by payload address and merge with free neighbors
    function automatic t_alloc_result predict_free(logic [ADDR_W-1:0] addr);
        t_alloc_result     r;
        logic [ADDR_W-1:0] rel;
        int                i;
        r   = '{address: '0, ok: 1'b0, free_total: '0};
        rel = addr - base_r;
        for (i = 0; i < blk_cnt; i++)
            if (longint'(tab_off[i]) + hdr_r == longint'(rel)) break;
        if (i < blk_cnt) begin
            r.ok = 1'b1;
            if (!tab_free[i]) begin
                tab_free[i] = 1'b1;
                while (i + 1 < blk_cnt && tab_free[i+1]) begin
                    tab_size[i] = OFS_W'(tab_size[i] + hdr_r + tab_size[i+1] + 1);
                    drop_entry(i + 1);
                end
                while (i > 0 && tab_free[i-1]) begin
                    tab_size[i-1] = OFS_W'(tab_size[i-1] + hdr_r + tab_size[i] + 1);
                    drop_entry(i);
                    i--;
                end
            end
        end
        r.free_total = free_bytes();
        return r;
    endfunction

    // compare results, then predict the transfer of this edge
    always @(posedge i_clk) begin
        t_alloc_result e;
        if (!i_rst_n) begin
            base_r  = '0;
            psize_r = POOL_LIMIT;
            hdr_r   = HDR_W'(24);
            rebuild_table();
            result_q.delete();
        end else begin
            if (i_valid) begin
                if (result_q.size() == 0) begin
                    $error("result with no request pending");
                    o_fail_count++;
                end else begin
                    e = result_q.pop_front();
                    if (i_address !== e.address) begin
                        $error("address: expected %h actual %h", e.address, i_address);
                        o_fail_count++;
                    end
                    if (i_ok !== e.ok) begin
                        $error("ok: expected %b actual %b", e.ok, i_ok);
                        o_fail_count++;
                    end
                    if (i_free_total !== e.free_total) begin
                        $error("free_total: expected %0d actual %0d",
                               e.free_total, i_free_total);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_func == FUNC_ALLOC) result_q.push_back(predict_alloc(i_request_size));
                else                      result_q.push_back(predict_free(i_block_address));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POOL_BASE: begin
                        base_r = i_cfg_wdata;
                    end
                    CFG_POOL_SIZE: begin
                        psize_r = i_cfg_wdata[PSIZE_W-1:0];
                        rebuild_table();
                    end
                    CFG_HEADER_SIZE: begin
                        hdr_r = i_cfg_wdata[HDR_W-1:0];
                        rebuild_table();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = result_q.size();
    end
endmodule

@@ sim/tb_first_fit_block_allocator.sv @@
// tb_first_fit_block_allocator: stimulus, watchdog and verdict for the allocator
// depends on ffa_pkg, first_fit_block_allocator and ffa_checker
`timescale 1ns / 1ps
module tb_first_fit_block_allocator;
    import ffa_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN      = 2 * MAX_BLOCKS + 20;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_func;
    logic [REQ_W-1:0]  i_request_size;
    logic [ADDR_W-1:0] i_block_address;
    logic              o_valid;
    logic [ADDR_W-1:0] o_address;
    logic              o_ok;
    logic [FSUM_W-1:0] o_free_total;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [ADDR_W-1:0] i_cfg_wdata;
    int                fail_count;
    int                pending;
    int                idle_cycles;
    logic [ADDR_W-1:0] live_addrs[$];
    logic [ADDR_W-1:0] cur_base;
    logic [HDR_W-1:0]  cur_hdr;

    first_fit_block_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_request_size(i_request_size),
        .i_block_address(i_block_address), .o_valid(o_valid), .o_address(o_address),
        .o_ok(o_ok), .o_free_total(o_free_total), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    ffa_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_func(i_func), .i_request_size(i_request_size),
        .i_block_address(i_block_address), .i_valid(o_valid), .i_address(o_address),
        .i_ok(o_ok), .i_free_total(o_free_total), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // remember granted addresses as candidates for release
    always @(posedge i_clk) begin
        if (o_valid && o_ok && o_address != '0) live_addrs.push_back(o_address);
    end

    task automatic send_request(logic func, logic [REQ_W-1:0] size, logic [ADDR_W-1:0] addr);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func          <= func;
        i_request_size  <= size;
        i_block_address <= addr;
        start           <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        @(negedge i_clk);
    endtask

    // register write once the block is idle
    task automatic write_reg(logic [1:0] idx, logic [ADDR_W-1:0] data);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        live_addrs.delete();
        if (idx == CFG_POOL_BASE) cur_base = data;
        if (idx == CFG_HEADER_SIZE) cur_hdr = data[HDR_W-1:0];
    endtask

    task automatic random_request();
        int                r;
        int                k;
        logic [ADDR_W-1:0] a;
        r = $urandom_range(0, 99);
        if (r < 48) begin
            send_request(FUNC_ALLOC, REQ_W'($urandom_range(0, 300)), $urandom);
        end else if (r < 53) begin
            send_request(FUNC_ALLOC, REQ_W'($urandom), $urandom);
        end else if (r < 88 && live_addrs.size() > 0) begin
            k = $urandom_range(0, live_addrs.size() - 1);
            a = live_addrs[k];
            // sometimes keep it so a later release hits an already free block
            if ($urandom_range(0, 9) != 0) live_addrs.delete(k);
            send_request(FUNC_FREE, REQ_W'($urandom), a);
        end else if (r < 94 && live_addrs.size() > 0) begin
            a = live_addrs[$urandom_range(0, live_addrs.size() - 1)] + 1;
            send_request(FUNC_FREE, REQ_W'($urandom), a);
        end else if (r < 97) begin
            send_request(FUNC_FREE, REQ_W'($urandom), cur_base + ADDR_W'(cur_hdr));
        end else begin
            send_request(FUNC_FREE, REQ_W'($urandom), $urandom);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] bases[6];
        logic [ADDR_W-1:0] psizes[6];
        logic [ADDR_W-1:0] hdrs[6];
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_func          = FUNC_ALLOC;
        i_request_size  = '0;
        i_block_address = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_POOL_BASE;
        i_cfg_wdata     = '0;
        idle_cycles     = 0;
        cur_base        = '0;
        cur_hdr         = HDR_W'(24);
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: exact fit of the whole pool, release, split, zero sizes
        send_request(FUNC_ALLOC, REQ_W'(1048576 - 24), '0);
        send_request(FUNC_ALLOC, REQ_W'(1), '0);
        send_request(FUNC_FREE, '0, ADDR_W'(24));
        send_request(FUNC_FREE, '0, ADDR_W'(24));
        send_request(FUNC_ALLOC, '0, '1);
        send_request(FUNC_ALLOC, '1, '0);
        send_request(FUNC_ALLOC, REQ_W'(100), '0);
        send_request(FUNC_FREE, '1, '1);
        send_request(FUNC_FREE, '0, '0);
        // fill the table until the split is refused
        repeat (66) send_request(FUNC_ALLOC, REQ_W'($urandom_range(0, 40)), '0);
        while (live_addrs.size() > 0) send_request(FUNC_FREE, '0, live_addrs.pop_front());

        // pool smaller than header: everything fails
        write_reg(CFG_POOL_SIZE, 32'd10);
        send_request(FUNC_ALLOC, '0, '0);
        send_request(FUNC_FREE, '0, 32'd24);
        // oversized pool saturates
        write_reg(CFG_POOL_SIZE, 32'h001F_FFFF);
        send_request(FUNC_ALLOC, REQ_W'(1048576 - 24), '0);

        // random phases over several register settings, extremes included
        bases  = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'h8000_0000, 32'h0, 32'h1234_5678};
        psizes = '{32'd1048576, 32'd4096, 32'd600, 32'd1048576, 32'd65, 32'd2000};
        hdrs   = '{32'd1, 32'd64, 32'd16, 32'd24, 32'd64, 32'd8};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_POOL_BASE, bases[ph] ^ (ph == 5 ? $urandom : 32'h0));
            write_reg(CFG_HEADER_SIZE, hdrs[ph]);
            write_reg(CFG_POOL_SIZE, psizes[ph]);
            repeat (68) random_request();
        end

        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
